// ===== rtl/core/rva_pkg.sv =====
// ---------------------------------------------------------------------------
// rva_pkg: shared types and constants of the axis-angle vector rotator
// Item and result records, fixed-point constants, CORDIC arctangent table
// and the stage map of the arithmetic pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rva_pkg;

   // Classified item as it waits in the queue.
   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic               zero;
      logic               flip;
      logic signed [31:0] ang;     // reduced angle, Q2.30
   } item_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               axis_zero;
      logic               saturated;
   } result_type;

   localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
   localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
   localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
   localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam int CORDIC_STEPS = 30;

   localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2
   };

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stage map of the back pipeline.
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int ST_SQR     = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_ROOT0   = 2;
   localparam int ST_PREP    = ST_ROOT0 + ROOT_STEPS;
   localparam int ST_DIV0    = ST_PREP + 1;
   localparam int ST_FIX     = ST_DIV0 + DIV_STEPS;
   localparam int ST_CORD0   = ST_FIX - CORDIC_STEPS;
   localparam int ST_TU      = ST_FIX + 1;
   localparam int ST_TT      = ST_TU + 1;
   localparam int ST_MAT     = ST_TT + 1;
   localparam int ST_PROD    = ST_MAT + 1;
   localparam int ST_OUT     = ST_PROD + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

endpackage

`default_nettype wire

// ===== rtl/core/rotate_vector_about_axis.sv =====
// ---------------------------------------------------------------------------
// rotate_vector_about_axis: rotates a vector about an arbitrary axis
// Axis-angle rotation in fixed point: Q16.16 vectors, Q4.28 angle.
// ---------------------------------------------------------------------------
// Usage. The req_ channel carries one vector, an axis of any length and an
// angle per transfer; the rsp_ channel returns the rotated vector, saturated
// to Q16.16, with a flag for a zero-length axis (vector passed unchanged)
// and a flag for clamping. Both channels are valid/ready.
//
// Throughput is one transfer per cycle unless the receiver stalls. The front
// classifies each item and writes it into a four-entry queue; the back is a
// 72-stage pipeline: the squares and their sum, 32 square-root stages, one
// set-up stage, 31 divider stages with the 30 CORDIC steps running alongside,
// and six stages for the matrix and the product. With nothing stalling, a
// result is presented from the last stage once its item has passed them all.
//
// When the receiver holds rsp_ready low with a result waiting, the whole
// back pipeline holds; the front keeps taking transfers until the queue is
// full, and only then drops req_ready.
//
// Reset (synchronous, active high) empties the queue and clears the stage
// valid flags; stage data and queue entries are not cleared; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotate_vector_about_axis (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_axis_zero,
   output logic               rsp_saturated
);
   import rva_pkg::*;

   item_type   front_item;
   item_type   head_item;
   logic       head_valid;
   logic       head_pop;
   result_type result;

   // Front: zero-axis test and angle folding, written straight into the queue.
   rva_front u_front (
      .req_vec_x  (req_vec_x),
      .req_vec_y  (req_vec_y),
      .req_vec_z  (req_vec_z),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .req_angle  (req_angle),
      .item       (front_item)
   );

   rva_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_valid),
      .wr_ready (req_ready),
      .wr_item  (front_item),
      .rd_valid (head_valid),
      .rd_pop   (head_pop),
      .rd_item  (head_item)
   );

   // Back: the arithmetic pipeline, its last stage being the result register.
   rva_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head_item),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (result)
   );

   assign rsp_out_x     = result.out_x;
   assign rsp_out_y     = result.out_y;
   assign rsp_out_z     = result.out_z;
   assign rsp_axis_zero = result.axis_zero;
   assign rsp_saturated = result.saturated;

   // Nothing is presented on the result side straight after a reset.
   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid directly after reset");

   // The queue can only fill up through a request transfer.
   a_full_by_transfer: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("queue became full without a request transfer");

   // A pass-through for a zero axis never reports clamping.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_axis_zero && rsp_saturated))
      else $error("zero-axis result flagged as saturated");

endmodule

`default_nettype wire

// ===== rtl/core/rva_front.sv =====
// ---------------------------------------------------------------------------
// rva_front: item classification
// Flags a zero-length axis and folds the angle into [-pi/2, pi/2].
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rva_front (
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_angle,
   output rva_pkg::item_type  item
);
   import rva_pkg::*;

   logic signed [33:0] ang_full;
   logic signed [33:0] ang_turn;
   logic signed [33:0] ang_half;
   logic               flip;

   // One wrap is enough: the Q4.28 range, [-8, 8), reaches less than a turn past +-pi.
   always_comb begin
      ang_full = 34'(req_angle);
      if (ang_full > ANG_PI) begin
         ang_turn = ang_full - ANG_TWO_PI;
      end else if (ang_full < -ANG_PI) begin
         ang_turn = ang_full + ANG_TWO_PI;
      end else begin
         ang_turn = ang_full;
      end
      flip = 1'b0;
      if (ang_turn > ANG_HALF_PI) begin
         ang_half = ang_turn - ANG_PI;
         flip     = 1'b1;
      end else if (ang_turn < -ANG_HALF_PI) begin
         ang_half = ang_turn + ANG_PI;
         flip     = 1'b1;
      end else begin
         ang_half = ang_turn;
      end
   end

   always_comb begin
      item.vec_x  = req_vec_x;
      item.vec_y  = req_vec_y;
      item.vec_z  = req_vec_z;
      item.axis_x = req_axis_x;
      item.axis_y = req_axis_y;
      item.axis_z = req_axis_z;
      item.zero   = (req_axis_x == 32'sd0) && (req_axis_y == 32'sd0) &&
                    (req_axis_z == 32'sd0);
      item.flip   = flip;
      item.ang    = {ang_half[29:0], 2'b00};   // Q4.28 to Q2.30
   end

endmodule

`default_nettype wire

// ===== rtl/core/rva_queue.sv =====
// ---------------------------------------------------------------------------
// rva_queue: item queue between front and back
// Small register FIFO; lets the front take transfers while the back stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rva_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  rva_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_pop,
   output rva_pkg::item_type rd_item
);
   import rva_pkg::*;

   item_type            mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign wr_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = mem[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rva_back.sv =====
// ---------------------------------------------------------------------------
// rva_back: rotation pipeline
// Square root, axis normalisation, CORDIC, matrix build and product,
// one step per stage; the whole pipeline holds while the result stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rva_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rva_pkg::item_type   head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rva_pkg::result_type rsp
);
   import rva_pkg::*;

   typedef struct {
      logic signed [31:0] vec [3];
      logic signed [31:0] axis [3];
      logic               zero;
      logic               flip;
      logic [62:0]        sqa [3];
      logic [63:0]        num;
      logic [63:0]        root;
      logic [31:0]        len;
      logic [61:0]        rem [3];
      logic [30:0]        quo [3];
      logic               neg [3];
      logic signed [31:0] u [3];
      logic signed [33:0] cx;
      logic signed [33:0] cy;
      logic signed [33:0] cz;
      logic signed [33:0] c;
      logic signed [33:0] s;
      logic signed [33:0] t;
      logic signed [33:0] tu [3];
      logic signed [33:0] su [3];
      logic signed [33:0] tt [6];
      logic signed [34:0] m [9];
      logic signed [66:0] p [9];
      logic signed [31:0] out [3];
      logic               sat;
   } stage_type;

   localparam logic signed [67:0] RND68 = 68'sd536870912;
   localparam logic signed [68:0] RND69 = 69'sd536870912;
   localparam logic signed [68:0] OUT_MAX = 69'sd2147483647;
   localparam logic signed [68:0] OUT_MIN = -69'sd2147483648;

   function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
      logic signed [67:0] pr;
      begin
         pr = 68'(a) * 68'(b);
         pr = pr + RND68;
         return pr[63:30];
      end
   endfunction

   stage_type              stg_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0]  vld_ff, vld_in;
   logic                   adv;

   assign adv      = !vld_ff[NUM_STAGES-1] || rsp_ready;
   assign head_pop = adv && head_valid;
   assign vld_in   = {vld_ff[NUM_STAGES-2:0], head_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      localparam int PRV = (g == 0) ? 0 : g - 1;
      localparam int RK  = (g >= ST_ROOT0 && g < ST_PREP) ? g - ST_ROOT0 : 0;
      localparam int DK  = (g >= ST_DIV0 && g < ST_FIX) ? ST_FIX - 1 - g : 0;
      localparam int CK  = (g >= ST_CORD0 && g < ST_FIX) ? g - ST_CORD0 : 0;
      localparam logic [63:0] ROOT_BIT = 64'd1 << (62 - 2 * RK);

      stage_type stg_in;

      always_comb begin
         logic signed [63:0] sqp;
         logic [64:0]        trial;
         logic [61:0]        dsh;
         logic [31:0]        mag;
         logic signed [33:0] dx;
         logic signed [33:0] dy;
         logic signed [33:0] cf;
         logic signed [33:0] sf;
         logic signed [68:0] sum;
         logic signed [68:0] rs;
         sqp   = '0;
         trial = '0;
         dsh   = '0;
         mag   = '0;
         dx    = '0;
         dy    = '0;
         cf    = '0;
         sf    = '0;
         sum   = '0;
         rs    = '0;
         if (g == ST_SQR) begin
            stg_in         = '{default: '0};
            stg_in.vec[0]  = head.vec_x;
            stg_in.vec[1]  = head.vec_y;
            stg_in.vec[2]  = head.vec_z;
            stg_in.axis[0] = head.axis_x;
            stg_in.axis[1] = head.axis_y;
            stg_in.axis[2] = head.axis_z;
            stg_in.zero    = head.zero;
            stg_in.flip    = head.flip;
            stg_in.cx      = CORDIC_GAIN;
            stg_in.cy      = '0;
            stg_in.cz      = 34'(head.ang);
            for (int i = 0; i < 3; i++) begin
               sqp           = stg_in.axis[i] * stg_in.axis[i];
               stg_in.sqa[i] = sqp[62:0];
            end
         end else begin
            stg_in = stg_ff[PRV];
         end

         if (g == ST_SUM) begin
            stg_in.num  = 64'(stg_in.sqa[0]) + 64'(stg_in.sqa[1]) + 64'(stg_in.sqa[2]);
            stg_in.root = '0;
         end

         // One result bit of the integer square root per stage.
         if (g >= ST_ROOT0 && g < ST_PREP) begin
            trial = {1'b0, stg_in.root} + {1'b0, ROOT_BIT};
            if ({1'b0, stg_in.num} >= trial) begin
               stg_in.num  = stg_in.num - trial[63:0];
               stg_in.root = (stg_in.root >> 1) + ROOT_BIT;
            end else begin
               stg_in.root = stg_in.root >> 1;
            end
         end

         if (g == ST_PREP) begin
            stg_in.len = stg_in.root[31:0];
            for (int i = 0; i < 3; i++) begin
               mag           = stg_in.axis[i][31] ? 32'(-stg_in.axis[i])
                                                  : 32'(stg_in.axis[i]);
               stg_in.rem[i] = {mag, 30'd0} + 62'(stg_in.root[31:1]);
               stg_in.quo[i] = '0;
               stg_in.neg[i] = stg_in.axis[i][31];
            end
         end

         // One quotient bit per stage; the quotient never reaches 2^31.
         if (g >= ST_DIV0 && g < ST_FIX) begin
            dsh = 62'(stg_in.len) << DK;
            for (int i = 0; i < 3; i++) begin
               if (stg_in.rem[i] >= dsh) begin
                  stg_in.rem[i]     = stg_in.rem[i] - dsh;
                  stg_in.quo[i][DK] = 1'b1;
               end
            end
         end

         if (g >= ST_CORD0 && g < ST_FIX) begin
            dx = stg_in.cy >>> CK;
            dy = stg_in.cx >>> CK;
            if (stg_in.cz >= 0) begin
               stg_in.cx = stg_in.cx - dx;
               stg_in.cy = stg_in.cy + dy;
               stg_in.cz = stg_in.cz - $signed(34'(ATAN_Q30[CK]));
            end else begin
               stg_in.cx = stg_in.cx + dx;
               stg_in.cy = stg_in.cy - dy;
               stg_in.cz = stg_in.cz + $signed(34'(ATAN_Q30[CK]));
            end
         end

         if (g == ST_FIX) begin
            for (int i = 0; i < 3; i++) begin
               stg_in.u[i] = stg_in.neg[i] ? -$signed({1'b0, stg_in.quo[i]})
                                           : $signed({1'b0, stg_in.quo[i]});
            end
            cf       = stg_in.flip ? -stg_in.cx : stg_in.cx;
            sf       = stg_in.flip ? -stg_in.cy : stg_in.cy;
            stg_in.c = cf;
            stg_in.s = sf;
            stg_in.t = Q30_ONE - cf;
         end

         if (g == ST_TU) begin
            for (int i = 0; i < 3; i++) begin
               stg_in.tu[i] = mul30(stg_in.t, 34'(stg_in.u[i]));
               stg_in.su[i] = mul30(stg_in.s, 34'(stg_in.u[i]));
            end
         end

         if (g == ST_TT) begin
            stg_in.tt[0] = mul30(stg_in.tu[0], 34'(stg_in.u[0]));
            stg_in.tt[1] = mul30(stg_in.tu[0], 34'(stg_in.u[1]));
            stg_in.tt[2] = mul30(stg_in.tu[0], 34'(stg_in.u[2]));
            stg_in.tt[3] = mul30(stg_in.tu[1], 34'(stg_in.u[1]));
            stg_in.tt[4] = mul30(stg_in.tu[1], 34'(stg_in.u[2]));
            stg_in.tt[5] = mul30(stg_in.tu[2], 34'(stg_in.u[2]));
         end

         if (g == ST_MAT) begin
            stg_in.m[0] = 35'(stg_in.tt[0]) + 35'(stg_in.c);
            stg_in.m[1] = 35'(stg_in.tt[1]) - 35'(stg_in.su[2]);
            stg_in.m[2] = 35'(stg_in.tt[2]) + 35'(stg_in.su[1]);
            stg_in.m[3] = 35'(stg_in.tt[1]) + 35'(stg_in.su[2]);
            stg_in.m[4] = 35'(stg_in.tt[3]) + 35'(stg_in.c);
            stg_in.m[5] = 35'(stg_in.tt[4]) - 35'(stg_in.su[0]);
            stg_in.m[6] = 35'(stg_in.tt[2]) - 35'(stg_in.su[1]);
            stg_in.m[7] = 35'(stg_in.tt[4]) + 35'(stg_in.su[0]);
            stg_in.m[8] = 35'(stg_in.tt[5]) + 35'(stg_in.c);
         end

         if (g == ST_PROD) begin
            for (int r = 0; r < 3; r++) begin
               for (int j = 0; j < 3; j++) begin
                  stg_in.p[3*r+j] = 67'(stg_in.m[3*r+j]) * 67'(stg_in.vec[j]);
               end
            end
         end

         if (g == ST_OUT) begin
            stg_in.sat = 1'b0;
            for (int r = 0; r < 3; r++) begin
               sum = 69'(stg_in.p[3*r]) + 69'(stg_in.p[3*r+1]) +
                     69'(stg_in.p[3*r+2]) + RND69;
               rs  = sum >>> 30;
               if (stg_in.zero) begin
                  stg_in.out[r] = stg_in.vec[r];
               end else if (rs > OUT_MAX) begin
                  stg_in.out[r] = OUT_MAX[31:0];
                  stg_in.sat    = 1'b1;
               end else if (rs < OUT_MIN) begin
                  stg_in.out[r] = OUT_MIN[31:0];
                  stg_in.sat    = 1'b1;
               end else begin
                  stg_in.out[r] = rs[31:0];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[g] <= stg_in;
         end
      end
   end

   assign rsp_valid     = vld_ff[NUM_STAGES-1];
   assign rsp.out_x     = stg_ff[NUM_STAGES-1].out[0];
   assign rsp.out_y     = stg_ff[NUM_STAGES-1].out[1];
   assign rsp.out_z     = stg_ff[NUM_STAGES-1].out[2];
   assign rsp.axis_zero = stg_ff[NUM_STAGES-1].zero;
   assign rsp.saturated = stg_ff[NUM_STAGES-1].sat;

endmodule

`default_nettype wire

// ===== bench/tb_rotate_vector_about_axis.sv =====
// ---------------------------------------------------------------------------
// tb_rotate_vector_about_axis: self-checking bench for the vector rotator
// Drives vector, axis and angle transfers with random gaps, predicts each
// rotated vector in fixed point and compares every returned transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotate_vector_about_axis;

   localparam int LIMIT_CYCLES = 1500000;
   localparam int DRAIN_CYCLES = 100;
   localparam int RANDOM_ITEMS = 840;
   localparam int HOLD_ITEMS   = 150;

   localparam longint Q30_ONE_L  = 64'sd1073741824;
   localparam longint Q30_HALF_L = 64'sd536870912;
   localparam longint TWO_PI_L   = 64'sd1686629713;
   localparam longint PI_L       = 64'sd843314857;
   localparam longint HALF_PI_L  = 64'sd421657428;
   localparam longint GAIN_L     = 64'sd652032874;

   // One request transfer.
   typedef struct {
      logic signed [31:0] vx, vy, vz, ax, ay, az, ang;
   } rotation_req_type;

   // One expected response transfer.
   typedef struct {
      logic signed [31:0] ox, oy, oz;
      logic               zero, sat;
   } rotated_vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic signed [31:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [31:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_axis_zero, rsp_saturated;

   rotation_req_type pending_reqs[$];     // filled by the stimulus, drained by the driver
   rotated_vec_type  expected_vecs[$];    // predictions in order of acceptance

   int  errors      = 0;
   int  sent_count  = 0;
   int  recv_count  = 0;
   int  zero_count  = 0;
   int  sat_count   = 0;
   int  cycle_count = 0;
   bit  hold_rsp    = 1'b0;            // long receiver hold-off, set by the stimulus
   bit  pause_req   = 1'b0;            // sender pause, set by the stimulus

   always #2 clock = ~clock;

   rotate_vector_about_axis dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_vec_x     (req_vec_x),
      .req_vec_y     (req_vec_y),
      .req_vec_z     (req_vec_z),
      .req_axis_x    (req_axis_x),
      .req_axis_y    (req_axis_y),
      .req_axis_z    (req_axis_z),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_axis_zero (rsp_axis_zero),
      .rsp_saturated (rsp_saturated)
   );

   // ------------------------------------------------------------------
   // Prediction. Floor shift on signed 64-bit values; >>> is arithmetic.
   // ------------------------------------------------------------------
   function automatic longint q30_mul(longint a, longint b);
      return (a * b + Q30_HALF_L) >>> 30;
   endfunction

   // Integer square root, bit by bit, of an unsigned 64-bit sum of squares.
   function automatic longint unsigned root_of(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint unit_of(longint a, longint unsigned len);
      longint unsigned mag = (a < 0) ? longint'(-a) : longint'(a);
      longint unsigned q = ((mag << 30) + (len >> 1)) / len;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Rounded, exact row-times-vector in Q30, split into whole and fraction
   // parts so the sum of three products cannot overflow.
   function automatic longint row_dot(longint m0, longint m1, longint m2,
                                      longint v0, longint v1, longint v2);
      longint p[3];
      longint hi = 0, lo = 0;
      p[0] = m0 * v0;
      p[1] = m1 * v1;
      p[2] = m2 * v2;
      for (int j = 0; j < 3; j++) begin
         hi += p[j] >>> 30;
         lo += p[j] & 64'h3FFF_FFFF;
      end
      return hi + ((lo + Q30_HALF_L) >>> 30);
   endfunction

   function automatic rotated_vec_type rotate_predict(rotation_req_type r);
      rotated_vec_type e;
      longint v[3], a[3], u[3], m[9];
      longint unsigned sq = 0, len;
      longint ang, x, y, z, dx, dy, c, s, t, tx, ty, tz, res;
      bit flip = 1'b0;
      v[0] = r.vx; v[1] = r.vy; v[2] = r.vz;
      a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
      for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
      e.zero = 1'b0;
      e.sat  = 1'b0;
      if (sq == 0) begin
         // Zero-length axis: the vector goes through unchanged.
         e.ox = r.vx; e.oy = r.vy; e.oz = r.vz;
         e.zero = 1'b1;
         return e;
      end
      len = root_of(sq);
      for (int i = 0; i < 3; i++) u[i] = unit_of(a[i], len);

      // Wrap the angle into one turn, then fold into the CORDIC range.
      ang = r.ang;
      while (ang > PI_L) ang -= TWO_PI_L;
      while (ang < -PI_L) ang += TWO_PI_L;
      if (ang > HALF_PI_L) begin
         ang -= PI_L;
         flip = 1'b1;
      end else if (ang < -HALF_PI_L) begin
         ang += PI_L;
         flip = 1'b1;
      end
      x = GAIN_L; y = 0; z = ang * 4;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(rva_pkg::ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; z += longint'(rva_pkg::ATAN_Q30[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;

      t  = Q30_ONE_L - c;
      tx = q30_mul(t, u[0]);
      ty = q30_mul(t, u[1]);
      tz = q30_mul(t, u[2]);
      m[0] = q30_mul(tx, u[0]) + c;
      m[1] = q30_mul(tx, u[1]) - q30_mul(s, u[2]);
      m[2] = q30_mul(tx, u[2]) + q30_mul(s, u[1]);
      m[3] = q30_mul(tx, u[1]) + q30_mul(s, u[2]);
      m[4] = q30_mul(ty, u[1]) + c;
      m[5] = q30_mul(ty, u[2]) - q30_mul(s, u[0]);
      m[6] = q30_mul(tx, u[2]) - q30_mul(s, u[1]);
      m[7] = q30_mul(ty, u[2]) + q30_mul(s, u[0]);
      m[8] = q30_mul(tz, u[2]) + c;

      for (int i = 0; i < 3; i++) begin
         res = row_dot(m[3*i], m[3*i+1], m[3*i+2], v[0], v[1], v[2]);
         if (res > 64'sd2147483647) begin
            res = 64'sd2147483647;
            e.sat = 1'b1;
         end else if (res < -64'sd2147483648) begin
            res = -64'sd2147483648;
            e.sat = 1'b1;
         end
         if (i == 0) e.ox = res[31:0];
         else if (i == 1) e.oy = res[31:0];
         else e.oz = res[31:0];
      end
      return e;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'd0;
         3, 4: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;  // about +-1.5
         5, 6: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic add_req(logic [31:0] vx, vy, vz, ax, ay, az, ang);
      rotation_req_type r;
      r.vx = vx; r.vy = vy; r.vz = vz;
      r.ax = ax; r.ay = ay; r.az = az;
      r.ang = ang;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   task automatic add_random_req();
      logic [31:0] ang;
      logic [31:0] ax, ay, az;
      // Mostly moderate angles, sometimes any word to exercise wrapping.
      ang = ($urandom_range(0, 3) == 0) ? $urandom
                                        : $urandom_range(0, 32'h6000_0000) - 32'h3000_0000;
      ax = rand_word(); ay = rand_word(); az = rand_word();
      if ($urandom_range(0, 24) == 0) begin
         ax = '0; ay = '0; az = '0;   // occasional zero-length axis
      end
      add_req(rand_word(), rand_word(), rand_word(), ax, ay, az, ang);
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_vecs.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: holds the payload steady until the transfer, then either
   // presents the next item at once or idles for a random gap.
   // ------------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sent_count <= sent_count + 1;
            expected_vecs.insert(expected_vecs.size(),
                                 rotate_predict('{req_vec_x, req_vec_y, req_vec_z,
                                                  req_axis_x, req_axis_y, req_axis_z,
                                                  req_angle}));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && !pause_req) begin
               rotation_req_type r;
               r = pending_reqs.pop_front();
               req_vec_x  <= r.vx;  req_vec_y  <= r.vy;  req_vec_z  <= r.vz;
               req_axis_x <= r.ax;  req_axis_y <= r.ay;  req_axis_z <= r.az;
               req_angle  <= r.ang;
               req_valid  <= 1'b1;
               // Mostly back to back, short gaps often, a long gap now and then.
               case ($urandom_range(0, 19))
                  0:          send_gap <= $urandom_range(20, 90);
                  1, 2, 3, 4: send_gap <= $urandom_range(1, 3);
                  default:    send_gap <= 0;
               endcase
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each response transfer against the oldest prediction
   // and chooses the ready level for the next cycle.
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            recv_count <= recv_count + 1;
            if (expected_vecs.size() == 0) begin
               $error("response transfer with no prediction outstanding");
               errors++;
            end else begin
               rotated_vec_type e;
               e = expected_vecs.pop_front();
               if (rsp_out_x !== e.ox) begin
                  $error("out_x: expected %0d, got %0d", e.ox, rsp_out_x);
                  errors++;
               end
               if (rsp_out_y !== e.oy) begin
                  $error("out_y: expected %0d, got %0d", e.oy, rsp_out_y);
                  errors++;
               end
               if (rsp_out_z !== e.oz) begin
                  $error("out_z: expected %0d, got %0d", e.oz, rsp_out_z);
                  errors++;
               end
               if (rsp_axis_zero !== e.zero) begin
                  $error("axis_zero: expected %0b, got %0b", e.zero, rsp_axis_zero);
                  errors++;
               end
               if (rsp_saturated !== e.sat) begin
                  $error("saturated: expected %0b, got %0b", e.sat, rsp_saturated);
                  errors++;
               end
               if (e.zero) zero_count <= zero_count + 1;
               if (e.sat) sat_count <= sat_count + 1;
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            case ($urandom_range(0, 29))
               0:             stall_left <= $urandom_range(20, 100);
               1, 2, 3, 4, 5: stall_left <= $urandom_range(1, 3);
               default:       stall_left <= 0;
            endcase
         end
      end
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence.
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: unit axes, quarter and half turns, wrapping angles,
      // zero-length axes, field extremes and saturating products.
      add_req(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h1921_FB54);  // x about z, +pi/2
      add_req(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0, 32'h3243_F6A9);  // y about x, pi
      add_req(0, 0, 32'h0001_0000, 0, 32'h0005_0000, 0, 32'hE6DE_04AC);  // z about y, -pi/2
      add_req(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1, 1, 1, 32'h7FFF_FFFF);
      add_req(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1, 1, 1, 32'h8000_0000);
      add_req(32'h1234_5678, 32'h8765_4321, 32'h0000_0001, 0, 0, 0, 32'h1000_0000);
      add_req(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h0001_0000, 32'hFFFF_0000, 0, 32'h0C90_FDAA);             // saturates
      add_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h2000_0000);
      add_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF);
      add_req(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 32'h8000_0000, 32'h3243_F6A8);
      add_req(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'h6487_ED51);   // full turn
      add_req(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000, 32'hCDBC_0957);   // x about z, -pi exactly
      wait_drained();

      // Long receiver hold-off while the sender keeps offering more items
      // than the pipeline and queue can hold, so the block drops req_ready.
      hold_rsp = 1'b1;
      repeat (HOLD_ITEMS) add_random_req();
      while (req_ready && pending_reqs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // Random stream; halfway through the sender pauses until all responses
      // have been returned.
      repeat (RANDOM_ITEMS / 2) add_random_req();
      while (pending_reqs.size() != 0) @(posedge clock);
      pause_req = 1'b1;
      while (req_valid || expected_vecs.size() != 0) @(posedge clock);
      pause_req = 1'b0;
      repeat (RANDOM_ITEMS / 2) add_random_req();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transfers in, %0d out; %0d zero-length axes, %0d clamped",
               sent_count, recv_count, zero_count, sat_count);
      if (errors == 0 && expected_vecs.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
